### hw/rtl/dgcd_pkg.sv
package dgcd_pkg;

    // Width and reset value of the node count register
    localparam int unsigned NODE_CNT_W = 5;
    localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 5'd16;

    // Width of a node index on the edge ports
    localparam int unsigned NODE_IDX_W = 4;

    // Search sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_ROOT = 4'b0010,
        ST_STEP = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // Verdict of one search step
    typedef struct packed {
        logic back_edge;   // a neighbor of the top node is on the stack
        logic fresh_any;   // a neighbor of the top node is still unvisited
    } t_step_flags;

endpackage

### hw/rtl/dgcd_adj_store.sv
module dgcd_adj_store #(
    parameter int MAX_NODES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_NODES)-1:0]  i_wr_from,
    input  logic [$clog2(MAX_NODES)-1:0]  i_wr_to,
    input  logic                          i_clear,
    input  logic [$clog2(MAX_NODES)-1:0]  i_rd_addr,
    output logic [MAX_NODES-1:0]          o_rd_row
);

    // Bit j of row i marks the edge i -> j
    logic [MAX_NODES-1:0] r_rows [MAX_NODES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < MAX_NODES; i++) begin
                r_rows[i] <= '0;
            end
        end else if (i_wr_en) begin
            r_rows[i_wr_from] <= r_rows[i_wr_from] | (MAX_NODES'(1) << i_wr_to);
        end
    end

    // One row read for the search
    assign o_rd_row = r_rows[i_rd_addr];

endmodule

### hw/rtl/dgcd_step_unit.sv
module dgcd_step_unit #(
    parameter int MAX_NODES = 16
) (
    input  logic [MAX_NODES-1:0]          i_row,
    input  logic [MAX_NODES-1:0]          i_used,
    input  logic [MAX_NODES-1:0]          i_visited,
    input  logic [MAX_NODES-1:0]          i_onstack,
    output dgcd_pkg::t_step_flags         o_flags,
    output logic [$clog2(MAX_NODES)-1:0]  o_fresh_idx
);

    localparam int IDX_W = $clog2(MAX_NODES);

    logic [MAX_NODES-1:0] w_nb;
    logic [MAX_NODES-1:0] w_fresh;

    // Neighbors in use, back-edge test and unvisited set
    assign w_nb    = i_row & i_used;
    assign w_fresh = w_nb & ~i_visited;

    assign o_flags.back_edge = |(w_nb & i_onstack);
    assign o_flags.fresh_any = |w_fresh;

    // Lowest unvisited neighbor
    always_comb begin
        o_fresh_idx = '0;
        for (int i = MAX_NODES - 1; i >= 0; i--) begin
            if (w_fresh[i]) begin
                o_fresh_idx = IDX_W'(i);
            end
        end
    end

endmodule

### hw/rtl/directed_graph_cycle_detector_core.sv
// Edge beats without the last mark are taken one per cycle (busy stays low).
// A beat with the last mark stores its edge, then the depth-first search runs with busy high:
// root checks over the n nodes in use, stack steps and the result cycle, one of them per cycle.
// The result appears on o_valid for one cycle at the end; the receiver cannot stall.
// Synchronous active-low reset clears the graph, marks and stack depth and sets node_count to 16.
module directed_graph_cycle_detector_core #(
    parameter int MAX_NODES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // edge beats
    input  logic                          start,
    output logic                          busy,
    input  logic [dgcd_pkg::NODE_IDX_W-1:0] i_from_node,
    input  logic [dgcd_pkg::NODE_IDX_W-1:0] i_to_node,
    input  logic                          i_edge_present,
    input  logic                          i_last_edge,
    // result
    output logic                          o_valid,
    output logic                          o_cycle_found,
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dgcd_pkg::NODE_CNT_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);

    dgcd_pkg::t_state r_state, n_state;

    logic [dgcd_pkg::NODE_CNT_W-1:0] r_node_count;
    logic [CNT_W-1:0]     r_root, n_root;
    logic [CNT_W-1:0]     r_depth, n_depth;
    logic [MAX_NODES-1:0] r_visited, n_visited;
    logic [MAX_NODES-1:0] r_onstack, n_onstack;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_stack [MAX_NODES];

    logic                 w_accept;
    logic                 w_edge_wr;
    logic [CNT_W-1:0]     w_n;
    logic [MAX_NODES-1:0] w_used;
    logic [CNT_W-1:0]     w_depth_m1;
    logic [IDX_W-1:0]     w_top;
    logic [IDX_W-1:0]     w_top_node;
    logic [MAX_NODES-1:0] w_row;
    logic [IDX_W-1:0]     w_root_idx;
    logic                 w_push;
    logic [IDX_W-1:0]     w_push_ptr;
    logic [IDX_W-1:0]     w_push_val;
    logic                 w_clear;
    dgcd_pkg::t_step_flags w_flags;
    logic [IDX_W-1:0]     w_fresh_idx;

    // Handshakes
    assign busy        = (r_state != dgcd_pkg::ST_IDLE);
    assign o_cfg_ready = !busy;
    assign w_accept    = start && !busy;
    assign w_edge_wr   = w_accept && i_edge_present
                      && (32'(i_from_node) < MAX_NODES) && (32'(i_to_node) < MAX_NODES);

    // Node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= dgcd_pkg::NODE_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node_count <= i_cfg_data;
        end
    end

    // Nodes in use, saturated, and their mask
    assign w_n = (32'(r_node_count) > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(r_node_count);

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            w_used[i] = (CNT_W'(i) < w_n);
        end
    end

    // Stack top slot, node held there, and root index
    assign w_depth_m1 = r_depth - CNT_W'(1);
    assign w_top      = w_depth_m1[IDX_W-1:0];
    assign w_top_node = r_stack[w_top];
    assign w_root_idx = r_root[IDX_W-1:0];

    dgcd_adj_store #(
        .MAX_NODES (MAX_NODES)
    ) u_adj (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_edge_wr),
        .i_wr_from (IDX_W'(i_from_node)),
        .i_wr_to   (IDX_W'(i_to_node)),
        .i_clear   (w_clear),
        .i_rd_addr (w_top_node),
        .o_rd_row  (w_row)
    );

    dgcd_step_unit #(
        .MAX_NODES (MAX_NODES)
    ) u_step (
        .i_row       (w_row),
        .i_used      (w_used),
        .i_visited   (r_visited),
        .i_onstack   (r_onstack),
        .o_flags     (w_flags),
        .o_fresh_idx (w_fresh_idx)
    );

    // Search sequencer
    always_comb begin
        n_state    = r_state;
        n_root     = r_root;
        n_depth    = r_depth;
        n_visited  = r_visited;
        n_onstack  = r_onstack;
        n_found    = r_found;
        w_push     = 1'b0;
        w_push_ptr = '0;
        w_push_val = '0;
        w_clear    = 1'b0;
        case (r_state)
            dgcd_pkg::ST_IDLE: begin
                if (w_accept && i_last_edge) begin
                    n_root  = '0;
                    n_state = dgcd_pkg::ST_ROOT;
                end
            end
            dgcd_pkg::ST_ROOT: begin
                if (r_root >= w_n) begin
                    n_found = 1'b0;
                    n_state = dgcd_pkg::ST_DONE;
                end else if (r_visited[w_root_idx]) begin
                    n_root = r_root + CNT_W'(1);
                end else begin
                    n_visited  = r_visited | (MAX_NODES'(1) << w_root_idx);
                    n_onstack  = r_onstack | (MAX_NODES'(1) << w_root_idx);
                    w_push     = 1'b1;
                    w_push_ptr = '0;
                    w_push_val = w_root_idx;
                    n_depth    = CNT_W'(1);
                    n_state    = dgcd_pkg::ST_STEP;
                end
            end
            dgcd_pkg::ST_STEP: begin
                if (w_flags.back_edge) begin
                    n_found = 1'b1;
                    n_state = dgcd_pkg::ST_DONE;
                end else if (w_flags.fresh_any && (r_depth < CNT_W'(MAX_NODES))) begin
                    // descend to the lowest unvisited neighbor
                    n_visited  = r_visited | (MAX_NODES'(1) << w_fresh_idx);
                    n_onstack  = r_onstack | (MAX_NODES'(1) << w_fresh_idx);
                    w_push     = 1'b1;
                    w_push_ptr = r_depth[IDX_W-1:0];
                    w_push_val = w_fresh_idx;
                    n_depth    = r_depth + CNT_W'(1);
                end else begin
                    // pop; back to the root scan once the stack empties
                    n_onstack = r_onstack & ~(MAX_NODES'(1) << w_top_node);
                    n_depth   = w_depth_m1;
                    if (w_depth_m1 == '0) begin
                        n_root  = r_root + CNT_W'(1);
                        n_state = dgcd_pkg::ST_ROOT;
                    end
                end
            end
            dgcd_pkg::ST_DONE: begin
                // result beat goes out; wipe the graph for the next one
                w_clear   = 1'b1;
                n_depth   = '0;
                n_visited = '0;
                n_onstack = '0;
                n_state   = dgcd_pkg::ST_IDLE;
            end
            default: begin
                n_state = dgcd_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dgcd_pkg::ST_IDLE;
            r_root    <= '0;
            r_depth   <= '0;
            r_visited <= '0;
            r_onstack <= '0;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_root    <= n_root;
            r_depth   <= n_depth;
            r_visited <= n_visited;
            r_onstack <= n_onstack;
            r_found   <= n_found;
        end
    end

    // Search stack
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[w_push_ptr] <= w_push_val;
        end
    end

    // Result beat
    assign o_valid       = (r_state == dgcd_pkg::ST_DONE);
    assign o_cycle_found = r_found;

    // Assertions
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result beat outside a search");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("more than one result beat per graph");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(MAX_NODES))
        else $error("stack depth over capacity");

    a_marks_track_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_onstack) == 32'(r_depth))
        else $error("on-stack marks disagree with stack depth");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> (r_depth == '0 && r_visited == '0))
        else $error("search state left over while idle");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_last_edge) |=> busy)
        else $error("last edge did not start a search");

endmodule
